// File: rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, codes and helpers of the bitshuffle block transpose unit.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned MaxItemBytes = 8;
  localparam int unsigned DataW        = 64;
  localparam int unsigned PlaneW       = 6;
  localparam int unsigned BlockW       = 29;
  localparam int unsigned CountW       = 32;
  localparam int unsigned TailW        = 3;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 4;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_MID_BLOCK   = 2'd1,
    STATUS_TAIL_EXCESS = 2'd2,
    STATUS_OVERFLOW    = 2'd3
  } status_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  localparam logic KIND_PLANE = 1'b0;
  localparam logic KIND_ITEM  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_ITEM_BYTES = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION  = 1'b1;

  typedef struct packed {
    logic [3:0] item_bytes;
    dir_e       direction;
  } cfg_t;

  // item_we: whole item to entry addr[2:0]; plane_we: bit i of data ORed into bit addr of
  // entry i (plane_clr clears all entries first)
  typedef struct packed {
    logic              item_we;
    logic              plane_we;
    logic              plane_clr;
    logic [PlaneW-1:0] addr;
    logic [DataW-1:0]  data;
  } buf_wr_t;

  typedef struct packed {
    logic [DataW-1:0]  data_res;
    logic              kind;
    logic [PlaneW-1:0] plane_index;
    logic [BlockW-1:0] block_index;
    logic [CountW-1:0] item_count;
    logic [TailW-1:0]  tail_count;
    logic [1:0]        status;
    logic              run_last;
  } res_t;

  // out-of-range sizes clamp to 1 .. MaxItemBytes
  function automatic logic [3:0] eff_size(logic [3:0] ib);
    logic [3:0] sz;
    if (ib == 4'd0) begin
      sz = 4'd1;
    end else if (ib > 4'(MaxItemBytes)) begin
      sz = 4'(MaxItemBytes);
    end else begin
      sz = ib;
    end
    return sz;
  endfunction

  function automatic logic [DataW-1:0] size_mask(logic [3:0] sz);
    logic [DataW-1:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < sz) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: rtl/bst_buffer.sv
// ----------------------------------------------------------------------------
// bst_buffer
// Eight-entry item store with a bit-plane gather port and an item read port.
// ----------------------------------------------------------------------------
module bst_buffer (
  input  logic                  clk_i,
  input  bst_pkg::buf_wr_t      wr_i,
  input  logic [5:0]            plane_sel_i,
  input  logic [2:0]            item_sel_i,
  output logic [7:0]            plane_bits_o,
  output logic [63:0]           item_o
);

  logic [63:0] mem_q [8];

  always_ff @(posedge clk_i) begin
    if (wr_i.item_we) begin
      mem_q[wr_i.addr[2:0]] <= wr_i.data;
    end
    if (wr_i.plane_we) begin
      for (int i = 0; i < 8; i++) begin
        if (wr_i.plane_clr) begin
          mem_q[i] <= {63'd0, wr_i.data[i]};
        end else begin
          // bits left by earlier plane writes within an open block are kept
          mem_q[i][wr_i.addr] <= mem_q[i][wr_i.addr] | wr_i.data[i];
        end
      end
    end
  end

  // bit i of the plane byte is bit plane_sel of item i
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      plane_bits_o[i] = mem_q[i][plane_sel_i];
    end
  end

  assign item_o = mem_q[item_sel_i];

endmodule

// File: rtl/bst_ctrl.sv
// ----------------------------------------------------------------------------
// bst_ctrl
// Sequencer: stream counters, buffer writes and one result per step.
// ----------------------------------------------------------------------------
module bst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bst_pkg::cfg_t      cfg_i,
  input  logic               in_fire_i,
  input  logic [63:0]        in_data_i,
  input  logic               in_tail_i,
  input  logic               in_last_i,
  output logic               idle_o,
  input  logic               emit_ok_i,
  output logic               res_valid_o,
  output bst_pkg::res_t      res_o,
  output bst_pkg::buf_wr_t   buf_wr_o,
  output logic [5:0]         plane_sel_o,
  output logic [2:0]         item_sel_o,
  input  logic [7:0]         plane_bits_i,
  input  logic [63:0]        item_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PLANES = 2'd1;
  localparam logic [1:0] S_ITEMS  = 2'd2;
  localparam logic [1:0] S_ONE    = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [2:0]  slot_q, slot_d;
  logic [5:0]  pc_q, pc_d;
  logic [28:0] bc_q, bc_d;
  logic [31:0] items_q, items_d;
  logic [2:0]  tails_q, tails_d;
  logic        ovf_q, ovf_d;
  logic        excess_q, excess_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  end_q, end_d;
  logic        dummy_q, dummy_d;
  logic [63:0] data_q;
  logic        last_q;

  logic [3:0]  sz;
  logic [63:0] mask;
  logic [5:0]  last_plane;
  logic [3:0]  items_inc;
  logic [32:0] items_sum;
  logic        count_en;
  logic        finish;
  logic        res_fire;
  logic        decode;
  bst_pkg::status_e st;

  assign sz         = bst_pkg::eff_size(cfg_i.item_bytes);
  assign mask       = bst_pkg::size_mask(sz);
  assign last_plane = 6'({sz, 3'b000} - 7'd1);
  assign decode     = (cfg_i.direction == bst_pkg::DIR_DECODE);
  assign items_sum  = {1'b0, items_q} + 33'(items_inc);
  assign idle_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q != S_IDLE);
  assign res_fire   = res_valid_o && emit_ok_i;
  assign plane_sel_o = cnt_q;
  assign item_sel_o  = cnt_q[2:0];

  always_comb begin
    if (!decode) begin
      st = ovf_q ? bst_pkg::STATUS_OVERFLOW : bst_pkg::STATUS_OK;
    end else if (pc_q != 6'd0) begin
      st = bst_pkg::STATUS_MID_BLOCK;
    end else if (excess_q) begin
      st = bst_pkg::STATUS_TAIL_EXCESS;
    end else if (ovf_q) begin
      st = bst_pkg::STATUS_OVERFLOW;
    end else begin
      st = bst_pkg::STATUS_OK;
    end
  end

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    pc_d      = pc_q;
    bc_d      = bc_q;
    tails_d   = tails_q;
    excess_d  = excess_q;
    cnt_d     = cnt_q;
    end_d     = end_q;
    dummy_d   = dummy_q;
    items_inc = 4'd1;
    count_en  = 1'b0;
    finish    = 1'b0;
    buf_wr_o  = '0;
    res_o     = '0;
    res_o.block_index = bc_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cnt_d = 6'd0;
          if (!decode) begin
            buf_wr_o.item_we = 1'b1;
            buf_wr_o.addr    = {3'd0, slot_q};
            buf_wr_o.data    = in_data_i & mask;
            count_en = 1'b1;
            slot_d   = slot_q + 3'd1;
            if (slot_q == 3'd7) begin
              state_d = S_PLANES;
            end else if (in_last_i) begin
              state_d = S_ITEMS;
              end_d   = slot_q;
            end
          end else if (in_tail_i) begin
            count_en = 1'b1;
            dummy_d  = 1'b0;
            state_d  = S_ONE;
            if (tails_q == 3'd7) begin
              excess_d = 1'b1;
            end else begin
              tails_d = tails_q + 3'd1;
            end
          end else begin
            buf_wr_o.plane_we  = 1'b1;
            buf_wr_o.plane_clr = (pc_q == 6'd0);
            buf_wr_o.addr      = pc_q;
            buf_wr_o.data      = {56'd0, in_data_i[7:0]};
            if (pc_q >= last_plane) begin
              pc_d      = 6'd0;
              items_inc = 4'd8;
              count_en  = 1'b1;
              end_d     = 3'd7;
              state_d   = S_ITEMS;
            end else begin
              pc_d = pc_q + 6'd1;
              if (in_last_i) begin
                dummy_d = 1'b1;
                state_d = S_ONE;
              end
            end
          end
        end
      end
      S_PLANES: begin
        res_o.data_res    = {56'd0, plane_bits_i};
        res_o.kind        = bst_pkg::KIND_PLANE;
        res_o.plane_index = cnt_q;
        if (cnt_q == last_plane) begin
          res_o.run_last = 1'b1;
          if (emit_ok_i) begin
            bc_d    = bc_q + 29'd1;
            finish  = last_q;
            state_d = S_IDLE;
          end
        end else if (emit_ok_i) begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_ITEMS: begin
        res_o.data_res = item_i & mask;
        res_o.kind     = bst_pkg::KIND_ITEM;
        if (cnt_q[2:0] == end_q) begin
          res_o.run_last = 1'b1;
          if (emit_ok_i) begin
            if (decode) begin
              bc_d = bc_q + 29'd1;
            end
            finish  = last_q;
            state_d = S_IDLE;
          end
        end else if (emit_ok_i) begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_ONE: begin
        res_o.data_res = dummy_q ? 64'd0 : (data_q & mask);
        res_o.kind     = dummy_q ? bst_pkg::KIND_PLANE : bst_pkg::KIND_ITEM;
        res_o.run_last = 1'b1;
        if (emit_ok_i) begin
          finish  = last_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    items_d = count_en ? items_sum[31:0] : items_q;
    ovf_d   = ovf_q | (count_en & items_sum[32]);

    // final result of a stream carries the totals, then the stream state clears
    if (finish) begin
      res_o.item_count = items_q;
      res_o.tail_count = decode ? tails_q : slot_q;
      res_o.status     = st;
      slot_d   = 3'd0;
      pc_d     = 6'd0;
      bc_d     = 29'd0;
      items_d  = 32'd0;
      tails_d  = 3'd0;
      ovf_d    = 1'b0;
      excess_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= 3'd0;
      pc_q     <= 6'd0;
      bc_q     <= 29'd0;
      items_q  <= 32'd0;
      tails_q  <= 3'd0;
      ovf_q    <= 1'b0;
      excess_q <= 1'b0;
      cnt_q    <= 6'd0;
      end_q    <= 3'd0;
      dummy_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      pc_q     <= pc_d;
      bc_q     <= bc_d;
      items_q  <= items_d;
      tails_q  <= tails_d;
      ovf_q    <= ovf_d;
      excess_q <= excess_d;
      cnt_q    <= cnt_d;
      end_q    <= end_d;
      dummy_q  <= dummy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_plane_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PLANES |-> cnt_q <= last_plane)
    else $error("plane counter past last plane");

  a_stream_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_o.run_last && last_q |=>
      items_q == 32'd0 && slot_q == 3'd0 && pc_q == 6'd0 && bc_q == 29'd0)
    else $error("stream state not cleared after final result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && !emit_ok_i |=> $stable(state_q) && $stable(cnt_q))
    else $error("sequencer advanced while output stalled");
`endif

endmodule

// File: rtl/bitshuffle_block_transpose_unit.sv
// ----------------------------------------------------------------------------
// bitshuffle_block_transpose_unit
// 8-item bit transpose of 1..8 byte items: encode to plane bytes, decode back.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: data; tuser: is_tail; tlast: last
// m_axis    out  m_axis_tvalid/tready      tdata: result fields; tuser: kind;
//                                          tlast: run_last
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// Results leave the sequencer through the output register, one per cycle unless
// m_axis_tready low stalls the sequencer in place: 8*item_bytes plane bytes for an
// encode block, 8 items for a decode block, the buffered items for an encode stream
// end, one for a tail item or a decode stream end. The block takes no item and no
// config write until the last result of the current transaction is in the output
// register. Reset clears counters and control; no clearing pass.
// ----------------------------------------------------------------------------
module bitshuffle_block_transpose_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // [63:0] data
  input  logic          s_axis_tuser,   // [0] is_tail
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [63:0] data_res, [69:64] plane_index, [98:70] block_index,
  // [130:99] item_count, [133:131] tail_count, [135:134] status
  output logic [135:0]  m_axis_tdata,
  output logic          m_axis_tuser,   // [0] kind
  output logic          m_axis_tlast,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [3:0]    cfg_data_i
);

  bst_pkg::cfg_t     cfg_q;
  bst_pkg::res_t     res, out_q;
  bst_pkg::buf_wr_t  buf_wr;
  logic              out_valid_q;
  logic              idle;
  logic              in_fire;
  logic              emit_ok;
  logic              res_valid;
  logic [5:0]        plane_sel;
  logic [2:0]        item_sel;
  logic [7:0]        plane_bits;
  logic [63:0]       item_rd;

  // config has priority over a waiting item
  assign cfg_ready_o   = idle;
  assign s_axis_tready = idle && !cfg_valid_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.item_bytes <= 4'd1;
      cfg_q.direction  <= bst_pkg::DIR_ENCODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bst_pkg::REG_ITEM_BYTES: cfg_q.item_bytes <= cfg_data_i;
        bst_pkg::REG_DIRECTION:  cfg_q.direction  <= bst_pkg::dir_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  bst_buffer u_buffer (
    .clk_i        (clk_i),
    .wr_i         (buf_wr),
    .plane_sel_i  (plane_sel),
    .item_sel_i   (item_sel),
    .plane_bits_o (plane_bits),
    .item_o       (item_rd)
  );

  bst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_fire_i    (in_fire),
    .in_data_i    (s_axis_tdata),
    .in_tail_i    (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .idle_o       (idle),
    .emit_ok_i    (emit_ok),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .buf_wr_o     (buf_wr),
    .plane_sel_o  (plane_sel),
    .item_sel_o   (item_sel),
    .plane_bits_i (plane_bits),
    .item_i       (item_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.status, out_q.tail_count, out_q.item_count,
                          out_q.block_index, out_q.plane_index, out_q.data_res};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.run_last;

endmodule

// File: verif/bitshuffle_block_transpose_unit_checker.sv
// ----------------------------------------------------------------------------
// bitshuffle_block_transpose_unit_checker
// Watches the input, output and config channels of the bit transpose unit,
// predicts the plane bytes / items / stream-end fields of every accepted
// input transaction and compares them in order with the output transactions.
// ----------------------------------------------------------------------------
module bitshuffle_block_transpose_unit_checker
  import bst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_tvalid_i,
  input  logic                in_tready_i,
  input  logic [63:0]         in_tdata_i,
  input  logic                in_tuser_i,
  input  logic                in_tlast_i,
  input  logic                out_tvalid_i,
  input  logic                out_tready_i,
  input  logic [135:0]        out_tdata_i,
  input  logic                out_tuser_i,
  input  logic                out_tlast_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  // configuration and stream state of the prediction
  logic [3:0]  cur_item_bytes;
  dir_e        cur_dir;
  logic [63:0] item_buf [8];
  logic [3:0]  slot;
  int unsigned plane_cnt;
  logic [28:0] block_cnt;
  logic [31:0] items_seen;
  logic [2:0]  tail_seen;
  logic        ovf;
  logic        tail_excess;

  res_t        burst [64];
  int unsigned burst_n;
  res_t        transposed_q [$];
  int unsigned errs;

  function automatic int unsigned clamp_size(logic [3:0] ib);
    if (ib == 4'd0) return 1;
    if (ib > 4'(MaxItemBytes)) return MaxItemBytes;
    return int'(ib);
  endfunction

  function automatic logic [63:0] byte_mask(int unsigned sz);
    if (sz >= 8) return '1;
    return (64'd1 << (8 * sz)) - 64'd1;
  endfunction

  function automatic int unsigned check_field(string name, logic [63:0] want,
                                              logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic push_res(logic [63:0] d, logic kind, logic [5:0] plane);
    res_t r;
    r             = '0;
    r.data_res    = d;
    r.kind        = kind;
    r.plane_index = plane;
    r.block_index = block_cnt;
    burst[burst_n] = r;
    burst_n++;
  endtask

  task automatic bump_items(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (items_seen == '1) ovf = 1'b1;
      items_seen++;
    end
  endtask

  // counts and status ride on the final result; the stream state restarts
  task automatic close_stream(status_e st);
    burst[burst_n-1].item_count = items_seen;
    burst[burst_n-1].tail_count = tail_seen;
    burst[burst_n-1].status     = st;
    slot        = '0;
    plane_cnt   = 0;
    block_cnt   = '0;
    items_seen  = '0;
    tail_seen   = '0;
    ovf         = 1'b0;
    tail_excess = 1'b0;
  endtask

  task automatic transpose_step(logic [63:0] d, logic tail, logic lst);
    int unsigned sz;
    logic [63:0] m;
    logic [7:0]  pb;
    status_e     st;
    sz      = clamp_size(cur_item_bytes);
    m       = byte_mask(sz);
    burst_n = 0;
    if (cur_dir == DIR_ENCODE) begin
      item_buf[slot[2:0]] = d & m;
      slot++;
      bump_items(1);
      if (slot >= 4'd8) begin
        for (int p = 0; p < 8 * sz; p++) begin
          for (int i = 0; i < 8; i++) pb[i] = item_buf[i][p];
          push_res({56'd0, pb}, KIND_PLANE, 6'(p));
        end
        block_cnt++;
        slot = '0;
      end
      if (lst) begin
        for (int i = 0; i < slot; i++) push_res(item_buf[i] & m, KIND_ITEM, '0);
        tail_seen = slot[2:0];
        close_stream(ovf ? STATUS_OVERFLOW : STATUS_OK);
      end
    end else begin
      if (tail) begin
        push_res(d & m, KIND_ITEM, '0);
        bump_items(1);
        if (tail_seen >= 3'd7) tail_excess = 1'b1;
        else tail_seen++;
      end else begin
        // a new block starts from cleared item words
        if (plane_cnt == 0) begin
          for (int i = 0; i < 8; i++) item_buf[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
          item_buf[i][plane_cnt % 64] = item_buf[i][plane_cnt % 64] | d[i];
        end
        plane_cnt++;
        if (plane_cnt >= 8 * sz) begin
          for (int i = 0; i < 8; i++) push_res(item_buf[i] & m, KIND_ITEM, '0);
          bump_items(8);
          block_cnt++;
          plane_cnt = 0;
        end
      end
      if (lst) begin
        if (burst_n == 0) push_res('0, KIND_PLANE, '0);
        if (plane_cnt != 0) st = STATUS_MID_BLOCK;
        else if (tail_excess) st = STATUS_TAIL_EXCESS;
        else if (ovf) st = STATUS_OVERFLOW;
        else st = STATUS_OK;
        close_stream(st);
      end
    end
    if (burst_n > 0) burst[burst_n-1].run_last = 1'b1;
    for (int i = 0; i < burst_n; i++) transposed_q.insert(transposed_q.size(), burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      cur_item_bytes = 4'd1;
      cur_dir        = DIR_ENCODE;
      slot           = '0;
      plane_cnt      = 0;
      block_cnt      = '0;
      items_seen     = '0;
      tail_seen      = '0;
      ovf            = 1'b0;
      tail_excess    = 1'b0;
      errs           = 0;
      transposed_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ITEM_BYTES) cur_item_bytes = cfg_data_i;
        else if (cfg_index_i == REG_DIRECTION) cur_dir = dir_e'(cfg_data_i[0]);
      end
      if (in_tvalid_i && in_tready_i) begin
        transpose_step(in_tdata_i, in_tuser_i, in_tlast_i);
      end
      if (out_tvalid_i && out_tready_i) begin
        got.data_res    = out_tdata_i[63:0];
        got.plane_index = out_tdata_i[69:64];
        got.block_index = out_tdata_i[98:70];
        got.item_count  = out_tdata_i[130:99];
        got.tail_count  = out_tdata_i[133:131];
        got.status      = out_tdata_i[135:134];
        got.kind        = out_tuser_i;
        got.run_last    = out_tlast_i;
        if (transposed_q.size() == 0) begin
          $error("unexpected result transaction: data_res %0h", got.data_res);
          errs++;
        end else begin
          want = transposed_q.pop_front();
          errs += check_field("data_res", want.data_res, got.data_res);
          errs += check_field("kind", want.kind, got.kind);
          errs += check_field("plane_index", want.plane_index, got.plane_index);
          errs += check_field("block_index", want.block_index, got.block_index);
          errs += check_field("item_count", want.item_count, got.item_count);
          errs += check_field("tail_count", want.tail_count, got.tail_count);
          errs += check_field("status", want.status, got.status);
          errs += check_field("run_last", want.run_last, got.run_last);
        end
      end
      mismatches_o <= errs;
      pending_o    <= transposed_q.size();
    end
  end

endmodule

// File: verif/bitshuffle_block_transpose_unit_tb.sv
// ----------------------------------------------------------------------------
// bitshuffle_block_transpose_unit_tb
// Drives encode and decode streams through the bit transpose unit: a directed
// opening, then random phases with varying item size, direction and
// handshake pressure. The checker module predicts and compares all results.
// ----------------------------------------------------------------------------
module bitshuffle_block_transpose_unit_tb;
  import bst_pkg::*;

  localparam int unsigned ItemTarget  = 370;
  localparam int unsigned DrainCycles = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [135:0]        m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches;
  int unsigned pending;
  logic [3:0]  cur_ib     = 4'd1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bitshuffle_block_transpose_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bitshuffle_block_transpose_unit_checker transpose_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .in_tlast_i   (s_axis_tlast),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tuser_i  (m_axis_tuser),
    .out_tlast_i  (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_ITEM_BYTES) cur_ib = val;
  endtask

  task automatic send_item(logic [63:0] d, logic tail, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= tail;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // pending is registered, hence the first wait
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_encode_stream(bit close);
    int unsigned n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      send_item(rand_word(), 1'($urandom), close && (i == n - 1));
    end
  endtask

  task automatic send_decode_stream(bit close);
    logic [63:0] words [$];
    logic        tails [$];
    int unsigned sz, nblk, ntail, shape;
    sz    = (cur_ib == 4'd0) ? 1 : (cur_ib > 4'(MaxItemBytes)) ? MaxItemBytes : cur_ib;
    shape = $urandom_range(9);
    if (shape <= 8) begin
      nblk  = $urandom_range(0, 2);
      ntail = (shape == 6) ? $urandom_range(8, 10) : $urandom_range(0, 7);
      // tails ahead of the planes
      if (shape == 8) begin
        for (int i = 0; i < ntail; i++) begin
          words.insert(words.size(), rand_word());
          tails.insert(tails.size(), 1'b1);
        end
      end
      for (int i = 0; i < nblk * 8 * sz; i++) begin
        words.insert(words.size(), rand_word());
        tails.insert(tails.size(), 1'b0);
      end
      // stream cut mid-block
      if (shape == 7) begin
        for (int i = 0; i < $urandom_range(1, 8 * sz - 1) && sz > 0; i++) begin
          words.insert(words.size(), rand_word());
          tails.insert(tails.size(), 1'b0);
        end
      end
      if (shape != 8) begin
        for (int i = 0; i < ntail; i++) begin
          words.insert(words.size(), rand_word());
          tails.insert(tails.size(), 1'b1);
        end
      end
    end else begin
      for (int i = 0; i < $urandom_range(1, 12); i++) begin
        words.insert(words.size(), rand_word());
        tails.insert(tails.size(), 1'($urandom));
      end
    end
    if (words.size() == 0) begin
      words.insert(words.size(), rand_word());
      tails.insert(tails.size(), 1'b1);
    end
    for (int i = 0; i < words.size(); i++) begin
      send_item(words[i], tails[i], close && (i == words.size() - 1));
    end
  endtask

  initial begin
    int unsigned phase;
    logic [3:0]  ib;
    dir_e        dir;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encode, 8-byte items: one full block of extreme patterns
    write_reg(REG_ITEM_BYTES, 4'd8);
    write_reg(REG_DIRECTION, CfgDataW'(DIR_ENCODE));
    send_item('1, 1'b0, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    send_item(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    send_item(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b1);
    wait_idle();

    // size 0 clamps to one byte; short stream passes through as tail items
    write_reg(REG_ITEM_BYTES, 4'd0);
    send_item('1, 1'b1, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b0);
    send_item('1, 1'b0, 1'b1);
    wait_idle();

    // decode: tail item, a full block, then a stream ending mid-block
    write_reg(REG_ITEM_BYTES, 4'd1);
    write_reg(REG_DIRECTION, CfgDataW'(DIR_DECODE));
    send_item('1, 1'b1, 1'b0);
    send_item(64'hFF, 1'b0, 1'b0);
    send_item('0, 1'b0, 1'b0);
    send_item(64'hA5, 1'b0, 1'b0);
    send_item(64'h5A, 1'b0, 1'b0);
    send_item('1, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0, 1'b1);
    wait_idle();
    send_item('1, 1'b0, 1'b1);

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      wait_idle();
      // mostly small sizes; open streams carry over into the new setting
      case ($urandom_range(9))
        0: ib = 4'd0;
        1: ib = 4'd15;
        2: ib = 4'd8;
        default: ib = 4'($urandom_range(1, 4));
      endcase
      dir = dir_e'($urandom_range(1));
      write_reg(REG_ITEM_BYTES, ib);
      write_reg(REG_DIRECTION, CfgDataW'(dir));
      repeat ($urandom_range(1, 3)) begin
        if (dir == DIR_ENCODE) send_encode_stream($urandom_range(9) != 0);
        else send_decode_stream($urandom_range(9) != 0);
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/bst_pkg.sv
rtl/bst_buffer.sv
rtl/bst_ctrl.sv
rtl/bitshuffle_block_transpose_unit.sv
verif/bitshuffle_block_transpose_unit_checker.sv
verif/bitshuffle_block_transpose_unit_tb.sv
